// ----- rtl/uer_pkg.sv -----
// uer_pkg: shared types, constants and register indexes for the echo ranger
// used by every module under rtl/, no dependencies of its own
package uer_pkg;

   localparam int COUNT_BITS      = 24;
   localparam int SCALE_FRAC_BITS = 24;
   localparam int SCALE_BITS      = 32;
   localparam int DIST_BITS       = 16;
   localparam int PULSE_BITS      = 16;
   localparam int PROD_BITS       = COUNT_BITS + SCALE_BITS;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 32;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLEAR_TICKS    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIGGER_TICKS  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ECHO_TICKS = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_METRIC     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_INCH     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_CM       = 3'd5;

   // register reset values
   localparam logic [PULSE_BITS-1:0] CLEAR_TICKS_RST    = 16'd100;
   localparam logic [PULSE_BITS-1:0] TRIGGER_TICKS_RST  = 16'd500;
   localparam logic [COUNT_BITS-1:0] MAX_ECHO_TICKS_RST = 24'd1900000;
   localparam logic [SCALE_BITS-1:0] SCALE_INCH_RST     = 32'd612140;
   localparam logic [SCALE_BITS-1:0] SCALE_CM_RST       = 32'd1554849;

   typedef struct packed {
      logic start_req;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic                 trigger_level;
      logic                 busy_res;
      logic                 result_valid;
      logic                 timed_out;
      logic [DIST_BITS-1:0] distance;
   } rsp_type;

   typedef struct packed {
      logic [PULSE_BITS-1:0] clear_ticks;
      logic [PULSE_BITS-1:0] trigger_ticks;
      logic [COUNT_BITS-1:0] max_echo_ticks;
      logic                  use_metric;
      logic [SCALE_BITS-1:0] scale_inch;
      logic [SCALE_BITS-1:0] scale_cm;
   } cfg_type;

   // sequencer result on its way to the scaling stage
   typedef struct packed {
      logic                  trigger_level;
      logic                  busy_res;
      logic                  result_valid;
      logic                  timed_out;
      logic [COUNT_BITS-1:0] ticks;
   } step_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_CLEAR = 5'b00010,
      PH_TRIG  = 5'b00100,
      PH_WAIT  = 5'b01000,
      PH_ECHO  = 5'b10000
   } phase_type;

endpackage

// ----- rtl/uer_csr.sv -----
// uer_csr: configuration register file of the echo ranger
// depends on uer_pkg for the register indexes, reset values and cfg_type
module uer_csr import uer_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CLEAR_TICKS:    cfg_in.clear_ticks    = csr_wdata[PULSE_BITS-1:0];
            CSR_TRIGGER_TICKS:  cfg_in.trigger_ticks  = csr_wdata[PULSE_BITS-1:0];
            CSR_MAX_ECHO_TICKS: cfg_in.max_echo_ticks = csr_wdata[COUNT_BITS-1:0];
            CSR_USE_METRIC:     cfg_in.use_metric     = csr_wdata[0];
            CSR_SCALE_INCH:     cfg_in.scale_inch     = csr_wdata[SCALE_BITS-1:0];
            CSR_SCALE_CM:       cfg_in.scale_cm       = csr_wdata[SCALE_BITS-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clear_ticks    <= CLEAR_TICKS_RST;
         cfg_ff.trigger_ticks  <= TRIGGER_TICKS_RST;
         cfg_ff.max_echo_ticks <= MAX_ECHO_TICKS_RST;
         cfg_ff.use_metric     <= 1'b0;
         cfg_ff.scale_inch     <= SCALE_INCH_RST;
         cfg_ff.scale_cm       <= SCALE_CM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/uer_seq.sv -----
// uer_seq: per-tick measurement sequencer (clear, trigger, wait, echo)
// depends on uer_pkg; feeds a registered step result to uer_dist
module uer_seq import uer_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_accept,
   input  req_type  req_data,
   input  logic     step_take,
   output logic     step_valid,
   output step_type step_data
);

   phase_type             phase_ff,      phase_in;
   logic [COUNT_BITS-1:0] tick_count_ff, tick_count_in;
   logic [COUNT_BITS-1:0] echo_width_ff, echo_width_in;
   logic                  step_valid_ff;
   step_type              step_ff,       step_in;

   logic [COUNT_BITS-1:0] limit;
   logic [COUNT_BITS:0]   cnt_inc;
   logic [COUNT_BITS:0]   width_inc;

   // a zero limit behaves as one
   assign limit = (cfg.max_echo_ticks == '0) ? COUNT_BITS'(1) : cfg.max_echo_ticks;

   always_comb begin
      phase_type             ph;
      logic [COUNT_BITS-1:0] cnt;
      logic [COUNT_BITS-1:0] wid;
      logic                  trig;
      logic                  done;
      logic                  tmo;

      ph   = phase_ff;
      cnt  = tick_count_ff;
      wid  = echo_width_ff;
      trig = 1'b0;
      done = 1'b0;
      tmo  = 1'b0;
      cnt_inc   = '0;
      width_inc = '0;

      if (ph == PH_IDLE && req_data.start_req) begin
         ph  = PH_CLEAR;
         cnt = '0;
      end

      // trigger held low
      if (ph == PH_CLEAR) begin
         if (cnt >= COUNT_BITS'(cfg.clear_ticks)) begin
            ph  = PH_TRIG;
            cnt = '0;
         end else begin
            cnt = cnt + COUNT_BITS'(1);
         end
      end

      // trigger pulse, a zero width falls straight through
      if (ph == PH_TRIG) begin
         if (cnt >= COUNT_BITS'(cfg.trigger_ticks)) begin
            ph  = PH_WAIT;
            cnt = '0;
         end else begin
            trig = 1'b1;
            cnt  = cnt + COUNT_BITS'(1);
         end
      end

      // wait for echo rise with timeout
      if (ph == PH_WAIT) begin
         if (req_data.echo_level) begin
            ph  = PH_ECHO;
            wid = '0;
         end else begin
            cnt_inc = {1'b0, cnt} + (COUNT_BITS+1)'(1);
            cnt     = cnt_inc[COUNT_BITS-1:0];
            if (cnt_inc >= {1'b0, limit}) begin
               ph   = PH_IDLE;
               done = 1'b1;
               tmo  = 1'b1;
               wid  = '0;
            end
         end
      end

      // echo width, capped at the limit
      if (ph == PH_ECHO) begin
         if (req_data.echo_level) begin
            width_inc = {1'b0, wid} + (COUNT_BITS+1)'(1);
            wid       = width_inc[COUNT_BITS-1:0];
            if (width_inc >= {1'b0, limit}) begin
               wid  = limit;
               ph   = PH_IDLE;
               done = 1'b1;
               tmo  = 1'b1;
            end
         end else begin
            ph   = PH_IDLE;
            done = 1'b1;
         end
      end

      phase_in      = ph;
      tick_count_in = cnt;
      echo_width_in = wid;

      step_in.trigger_level = trig;
      step_in.busy_res      = (ph != PH_IDLE);
      step_in.result_valid  = done;
      step_in.timed_out     = tmo;
      step_in.ticks         = done ? wid : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         echo_width_ff <= '0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         echo_width_ff <= echo_width_in;
      end
   end

   // a tick is only accepted while this stage is empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         step_valid_ff <= 1'b0;
      end else if (req_accept) begin
         step_valid_ff <= 1'b1;
      end else if (step_take) begin
         step_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         step_ff <= step_in;
      end
   end

   assign step_valid = step_valid_ff;
   assign step_data  = step_ff;

   a_tmo_only_on_done : assert property (@(posedge clock) disable iff (reset)
      step_valid_ff && step_ff.timed_out |-> step_ff.result_valid)
      else $error("timeout flag without completion");

   a_done_leaves_idle : assert property (@(posedge clock) disable iff (reset)
      step_valid_ff && step_ff.result_valid |-> !step_ff.busy_res && phase_ff == PH_IDLE)
      else $error("completion while sequencer still busy");

   a_trig_in_pulse : assert property (@(posedge clock) disable iff (reset)
      step_valid_ff && step_ff.trigger_level |-> phase_ff == PH_TRIG)
      else $error("trigger high outside the pulse phase");

   a_step_holds : assert property (@(posedge clock) disable iff (reset)
      step_valid_ff && !step_take |=> step_valid_ff && $stable(step_ff))
      else $error("held step result changed");

endmodule

// ----- rtl/uer_dist.sv -----
// uer_dist: tick count to Q8.8 distance scaling and the result register
// depends on uer_pkg; takes the step result from uer_seq
module uer_dist import uer_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     step_valid,
   input  step_type step_data,
   output logic     step_take,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   logic [SCALE_BITS-1:0] scale;
   logic [PROD_BITS-1:0]  prod;

   assign scale = cfg.use_metric ? cfg.scale_cm : cfg.scale_inch;
   assign prod  = PROD_BITS'(step_data.ticks) * PROD_BITS'(scale);

   always_comb begin
      rsp_in.trigger_level = step_data.trigger_level;
      rsp_in.busy_res      = step_data.busy_res;
      rsp_in.result_valid  = step_data.result_valid;
      rsp_in.timed_out     = step_data.timed_out;
      // saturate once the integer part no longer fits
      if (prod[PROD_BITS-1:SCALE_FRAC_BITS+DIST_BITS] != '0) begin
         rsp_in.distance = '1;
      end else begin
         rsp_in.distance = prod[SCALE_FRAC_BITS+DIST_BITS-1:SCALE_FRAC_BITS];
      end
   end

   assign step_take = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_take) begin
         rsp_valid_ff <= step_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step_take && step_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/ultrasonic_echo_ranger.sv -----
// ultrasonic_echo_ranger: top level of the ultrasonic echo ranging block
// depends on uer_pkg, uer_csr, uer_seq and uer_dist
//
// usage
// - each req transaction is one tick: start_req asks for a measurement when
//   idle, echo_level is the sampled echo pin for that tick
// - every req transaction yields exactly one rsp transaction carrying the
//   trigger pin level, busy, and on the completing tick result_valid,
//   timed_out and the Q8.8 distance (inch or cm, saturated at 65535)
// - a transaction moves when valid is high and stall is low
// - a tick passes the sequencer register, then the scaling stage
//   with its 24x32 multiply feeding the rsp register
// - throughput is one transaction per cycle unless req_stall is high; the
//   sequencer state steps once per tick, the multiply sits in its own stage
// - req_stall rises only when both stages hold data and rsp_stall is high,
//   so a waiting result never blocks the next tick while a stage is free
// - reset is synchronous: sequencer idle, counters zero, both stages empty,
//   registers back to their defaults
// - csr writes are always taken (csr_ready tied high); write only while
//   no measurement is running and the pipeline has drained
module ultrasonic_echo_ranger import uer_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // tick input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   // per-tick results
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type  cfg;
   logic     step_take;
   logic     step_valid;
   step_type step_data;
   logic     req_accept;

   // sequencer stage is free when empty or when it drains this cycle
   assign req_stall  = step_valid && !step_take;
   assign req_accept = req_valid && !req_stall;

   uer_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // phase machine and tick / echo-width counters
   uer_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_accept (req_accept),
      .req_data   (req_data),
      .step_take  (step_take),
      .step_valid (step_valid),
      .step_data  (step_data)
   );

   // scale multiply, saturation and output register
   uer_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_valid (step_valid),
      .step_data  (step_data),
      .step_take  (step_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
